>>> hdl/pva_pkg.sv
package pva_pkg;

    localparam logic [15:0] PITCH_EMPTY = 16'h8000;
    localparam logic [3:0]  VOICES_RST  = 4'd8;
    localparam int          OUT_VOICE_W = 3;

    localparam logic CMD_NOTE_ON  = 1'b0;
    localparam logic CMD_NOTE_OFF = 1'b1;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_INIT,
        OP_ASSIGN,
        OP_STEAL,
        OP_RELEASE
    } pva_op_t;

    typedef struct packed {
        logic               command;
        logic signed [15:0] pitch;
    } pva_in_t;

    typedef struct packed {
        logic [OUT_VOICE_W-1:0] voice;
        logic                   found;
    } pva_out_t;

    typedef struct packed {
        pva_op_t     op;
        logic [15:0] pitch;
        logic        push_age;
        logic        push_free;
    } pva_ctrl_t;

endpackage

>>> hdl/pva_cell.sv
module pva_cell #(
    parameter int IDX_W     = 3,
    parameter int CNT_W     = 4,
    parameter int CELL_IDX  = 0,
    parameter int RST_COUNT = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pva_pkg::pva_ctrl_t   ctrl,
    input  logic [IDX_W-1:0]     voice,
    input  logic [CNT_W-1:0]     count_n,
    input  logic [CNT_W-1:0]     busy,
    input  logic [CNT_W-1:0]     free_cnt,
    input  logic [15:0]          probe_pitch,
    input  logic                 first_in,
    output logic                 first_out,
    output logic                 hit,
    input  logic                 seen_in,
    output logic                 seen_out,
    input  logic [IDX_W-1:0]     age_right,
    input  logic [IDX_W-1:0]     free_right,
    output logic [IDX_W-1:0]     age_q,
    output logic [IDX_W-1:0]     free_q
);
    import pva_pkg::*;

    localparam logic [CNT_W-1:0] POS       = CNT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] POS_NEXT  = CNT_W'(CELL_IDX + 1);
    localparam logic [IDX_W-1:0] OWN_VOICE = IDX_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] RST_FREE  = (CELL_IDX < RST_COUNT) ? IDX_W'(CELL_IDX) : '0;

    logic [15:0]      pitch_reg, pitch_next;
    logic [IDX_W-1:0] age_reg, age_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic             active;
    logic             own;
    logic             match_here;
    logic             age_match;

    assign active     = POS < count_n;
    assign own        = voice == OWN_VOICE;
    assign match_here = active && (pitch_reg == probe_pitch);
    assign hit        = match_here && !first_in;
    assign first_out  = first_in || match_here;
    assign age_match  = (POS < busy) && (age_reg == voice);
    assign seen_out   = seen_in || age_match;
    assign age_q      = age_reg;
    assign free_q     = free_reg;

    always_comb
    begin
        pitch_next = pitch_reg;
        age_next   = age_reg;
        free_next  = free_reg;
        case (ctrl.op)
            OP_INIT:
            begin
                pitch_next = PITCH_EMPTY;
                free_next  = active ? OWN_VOICE : '0;
            end
            OP_ASSIGN:
            begin
                if (own)
                begin
                    pitch_next = ctrl.pitch;
                end
                free_next = free_right;
                if (ctrl.push_age && (POS == busy))
                begin
                    age_next = voice;
                end
            end
            OP_STEAL:
            begin
                if (own)
                begin
                    pitch_next = ctrl.pitch;
                end
                if (POS_NEXT < busy)
                begin
                    age_next = age_right;
                end
                else if (POS_NEXT == busy)
                begin
                    age_next = voice;
                end
            end
            OP_RELEASE:
            begin
                if (own)
                begin
                    pitch_next = PITCH_EMPTY;
                end
                if ((seen_in || age_match) && (POS_NEXT < busy))
                begin
                    age_next = age_right;
                end
                if (ctrl.push_free && (POS == free_cnt))
                begin
                    free_next = voice;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= PITCH_EMPTY;
            free_reg  <= RST_FREE;
        end
        else
        begin
            pitch_reg <= pitch_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg <= age_next;
    end

endmodule

>>> hdl/poly_voice_allocator_unit.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_data   (command, pitch)
// out       output     out_valid / out_ready   out_data  (voice, found)
// cfg       input      cfg_we                  cfg_data  (voices_in_use)
//
// Each word passes through S_IDLE, where the accept cycle searches the cell row
// and registers the result, then S_APPLY, which updates every cell at once.
// After reset all voices are empty and the free queue holds voices 0 to N-1.
// A configuration write restores that state for the new voice count.
// A result waits in the output register; a new word is taken once it is taken.
module poly_voice_allocator_unit #(
    parameter int MAX_VOICES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pva_pkg::pva_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pva_pkg::pva_out_t out_data,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_data
);
    import pva_pkg::*;

    localparam int IDX_W     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W     = $clog2(MAX_VOICES + 1);
    localparam int RST_COUNT = (int'(VOICES_RST) > MAX_VOICES) ? MAX_VOICES : int'(VOICES_RST);
    localparam logic [CNT_W-1:0] RST_N = CNT_W'(RST_COUNT);

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [3:0] v);
        logic [CNT_W-1:0] r;
        if (v == 4'd0)
        begin
            r = CNT_W'(1);
        end
        else if (32'(v) > MAX_VOICES)
        begin
            r = CNT_W'(MAX_VOICES);
        end
        else
        begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    state_t           state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    pva_out_t         out_data_reg, out_data_next;
    logic [3:0]       voices_reg, voices_next;
    logic [CNT_W-1:0] busy_reg, busy_next;
    logic [CNT_W-1:0] free_reg, free_next;
    pva_op_t          op_reg, op_next;
    logic [15:0]      pitch_reg, pitch_next;
    logic [IDX_W-1:0] voice_reg, voice_next;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] cell_n;
    pva_ctrl_t        ctrl;
    logic             in_fire;
    logic             pitch_ok;
    logic [IDX_W-1:0] hit_voice;
    pva_op_t          acc_op;
    logic [IDX_W-1:0] acc_voice;
    logic [IDX_W+OUT_VOICE_W-1:0] voice_ext;

    logic             first_c [0:MAX_VOICES];
    logic             seen_c  [0:MAX_VOICES];
    logic [IDX_W-1:0] age_c   [0:MAX_VOICES];
    logic [IDX_W-1:0] free_c  [0:MAX_VOICES];
    logic [MAX_VOICES-1:0] hit_vec;

    assign n_eff  = clamp_count(voices_reg);
    assign cell_n = cfg_we ? clamp_count(cfg_data) : n_eff;

    assign first_c[0]         = 1'b0;
    assign seen_c[0]          = 1'b0;
    assign age_c[MAX_VOICES]  = '0;
    assign free_c[MAX_VOICES] = '0;

    for (genvar k = 0; k < MAX_VOICES; k++)
    begin : g_cell
        pva_cell #(
            .IDX_W     (IDX_W),
            .CNT_W     (CNT_W),
            .CELL_IDX  (k),
            .RST_COUNT (RST_COUNT)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .voice       (voice_reg),
            .count_n     (cell_n),
            .busy        (busy_reg),
            .free_cnt    (free_reg),
            .probe_pitch ($unsigned(in_data.pitch)),
            .first_in    (first_c[k]),
            .first_out   (first_c[k+1]),
            .hit         (hit_vec[k]),
            .seen_in     (seen_c[k]),
            .seen_out    (seen_c[k+1]),
            .age_right   (age_c[k+1]),
            .free_right  (free_c[k+1]),
            .age_q       (age_c[k]),
            .free_q      (free_c[k])
        );
    end

    always_comb
    begin
        hit_voice = '0;
        for (int k = 0; k < MAX_VOICES; k++)
        begin
            if (hit_vec[k])
            begin
                hit_voice = hit_voice | IDX_W'(k);
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pitch_ok  = $unsigned(in_data.pitch) != PITCH_EMPTY;

    always_comb
    begin
        acc_op    = OP_IDLE;
        acc_voice = '0;
        if (pitch_ok)
        begin
            if (in_data.command == CMD_NOTE_ON)
            begin
                if (free_reg != '0)
                begin
                    acc_op    = OP_ASSIGN;
                    acc_voice = free_c[0];
                end
                else if (busy_reg != '0)
                begin
                    acc_op    = OP_STEAL;
                    acc_voice = age_c[0];
                end
            end
            else if (first_c[MAX_VOICES])
            begin
                acc_op    = OP_RELEASE;
                acc_voice = hit_voice;
            end
        end
        voice_ext = (IDX_W + OUT_VOICE_W)'(acc_voice);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        voices_next    = voices_reg;
        busy_next      = busy_reg;
        free_next      = free_reg;
        op_next        = op_reg;
        pitch_next     = pitch_reg;
        voice_next     = voice_reg;

        ctrl.op        = OP_IDLE;
        ctrl.pitch     = pitch_reg;
        ctrl.push_age  = busy_reg < n_eff;
        ctrl.push_free = free_reg < n_eff;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next          = S_APPLY;
                    op_next             = acc_op;
                    pitch_next          = $unsigned(in_data.pitch);
                    voice_next          = acc_voice;
                    out_valid_next      = 1'b1;
                    out_data_next.found = acc_op != OP_IDLE;
                    out_data_next.voice = (acc_op != OP_IDLE) ? voice_ext[OUT_VOICE_W-1:0] : '0;
                end
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
                ctrl.op    = op_reg;
                case (op_reg)
                    OP_ASSIGN:
                    begin
                        free_next = free_reg - CNT_W'(1);
                        busy_next = busy_reg + CNT_W'(ctrl.push_age);
                    end
                    OP_RELEASE:
                    begin
                        busy_next = busy_reg - CNT_W'(seen_c[MAX_VOICES]);
                        free_next = free_reg + CNT_W'(ctrl.push_free);
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            ctrl.op     = OP_INIT;
            voices_next = cfg_data;
            busy_next   = '0;
            free_next   = clamp_count(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            voices_reg    <= VOICES_RST;
            busy_reg      <= '0;
            free_reg      <= RST_N;
            op_reg        <= OP_IDLE;
            pitch_reg     <= PITCH_EMPTY;
            voice_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            voices_reg    <= voices_next;
            busy_reg      <= busy_next;
            free_reg      <= free_next;
            op_reg        <= op_next;
            pitch_reg     <= pitch_next;
            voice_reg     <= voice_next;
        end
    end

endmodule
